// ===== rtl/spr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slotted page record store: shared definitions
// Field widths, action codes and status codes used by the channel interfaces
// and the core.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned STAGE_BYTES = 4096;

  typedef enum logic [ACTION_W-1:0] {
    ACT_STAGE  = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_UPDATE = 3'd3,
    ACT_DELETE = 3'd4,
    ACT_READ   = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

endpackage
`default_nettype wire

// ===== rtl/spr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slotted page record store: channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface spr_req_if;
  import spr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PAGE_W-1:0]   page_id;
  logic [SLOT_W-1:0]   slot_id;
  logic [INDEX_W-1:0]  byte_index;
  logic [BYTE_W-1:0]   data_byte;
  logic [LEN_W-1:0]    record_length;

  modport source (output valid, action, page_id, slot_id, byte_index, data_byte,
                  record_length, input ready);
  modport sink   (input valid, action, page_id, slot_id, byte_index, data_byte,
                  record_length, output ready);
endinterface

interface spr_rsp_if;
  import spr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   result_page;
  logic [SLOT_W-1:0]   result_slot;
  logic [INDEX_W-1:0]  record_offset;
  logic [LEN_W-1:0]    stored_length;
  logic [BYTE_W-1:0]   read_data;

  modport source (output valid, status, result_page, result_slot, record_offset,
                  stored_length, read_data, input ready);
  modport sink   (input valid, status, result_page, result_slot, record_offset,
                  stored_length, read_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/spr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slotted page record store: byte RAM
// Single-port byte-wide memory with registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output      logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/slotted_page_record_store_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slotted page record store core
// Sequencer over a single-port page RAM and a staging RAM.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and answered with one response beat, and
// no new request is taken while a response beat waits to be accepted. A stage
// request is answered by the same edge that takes it. A lookup, update or
// delete answers not found when the page is beyond those in use or the slot
// is not below the slot count, and an update of a deleted slot answers deleted.
// An update that fits overwrites the record in place; one that does not fit
// tombstones the old slot and then runs an insert. Insert rejects a record
// that is too large, then reads the header of each page in use until one has
// room, copies the record from the staging RAM and writes its directory entry
// and the page header. If no page in use has room, a new page is opened; a
// full store answers full. The page RAM has a single byte-wide port, which
// every header read, record copy and directory write goes through. A response
// that the receiver holds off keeps the next request waiting. No clearing pass
// is run after reset.
module slotted_page_record_store_core #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned PAGE_COUNT = 16
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  spr_req_if.sink    req_i,
  spr_rsp_if.source  rsp_o
);
  import spr_pkg::*;

  localparam int unsigned AW  = $clog2(PAGE_COUNT * PAGE_BYTES);
  localparam int unsigned PCW = $clog2(PAGE_COUNT + 1);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_RB        = 19'h00002,
    S_RD        = 19'h00004,
    S_WR        = 19'h00008,
    S_COPY      = 19'h00010,
    S_INS_START = 19'h00020,
    S_INS_PG    = 19'h00040,
    S_INS_CHK   = 19'h00080,
    S_INS_NEW   = 19'h00100,
    S_PLACE_W   = 19'h00200,
    S_PLACE_H   = 19'h00400,
    S_FIN_INS   = 19'h00800,
    S_SO_START  = 19'h01000,
    S_SO_HCHK   = 19'h02000,
    S_SO_ACT    = 19'h04000,
    S_UPD_W     = 19'h08000,
    S_FIN_UPD   = 19'h10000,
    S_FIN_DEL   = 19'h20000,
    S_SPARE     = 19'h40000
  } state_e;

  state_e          state_q, state_d, ret_q, ret_d;
  logic [PCW-1:0]  piu_q, piu_d, pg_q, pg_d;
  logic [3:0]      pid_q, pid_d;
  logic [9:0]      slot_q, slot_d;
  logic [11:0]     need_q, need_d;
  logic [2:0]      act_q, act_d;
  logic [15:0]     sc_q, sc_d, off_q, off_d, aoff_q, aoff_d;
  logic [AW-1:0]   pbase_q, pbase_d;
  logic [2:0]      rk_q, rk_d, wn_q, wn_d;
  logic [31:0]     rbuf_q, rbuf_d, wbuf_q, wbuf_d;
  logic [12:0]     cnt_q, cnt_d;

  logic            m_we, s_we;
  logic [AW-1:0]   m_addr;
  logic [11:0]     s_addr;
  logic [7:0]      m_wdata, m_rdata, s_wdata, s_rdata;

  logic            fin;
  status_e         f_st;
  logic [3:0]      f_page;
  logic [9:0]      f_slot;
  logic [11:0]     f_off, f_len;
  logic [7:0]      f_data;

  logic            ov_q;
  status_e         st_q;
  logic [3:0]      rpage_q;
  logic [9:0]      rslot_q;
  logic [11:0]     roff_q, rlen_q;
  logic [7:0]      rdat_q;

  logic            accept;
  logic [17:0]     dir_end, room;
  logic [15:0]     hdr_sc, hdr_fp, slot_ent;

  assign req_i.ready = (state_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign hdr_sc   = rbuf_q[15:0];
  assign hdr_fp   = rbuf_q[31:16];
  assign dir_end  = 18'd4 + {hdr_sc, 2'b00};
  assign room     = (18'(hdr_fp) > dir_end) ? 18'(hdr_fp) - dir_end : 18'd0;
  assign slot_ent = 16'd4 + {4'd0, slot_q, 2'b00};

  spr_ram #(.DEPTH(PAGE_COUNT * PAGE_BYTES), .AW(AW)) u_page_ram (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wdata), .rdata_o(m_rdata)
  );

  spr_ram #(.DEPTH(STAGE_BYTES), .AW(12)) u_stage_ram (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata)
  );

  always_comb begin
    state_d = state_q;  ret_d  = ret_q;   piu_d = piu_q;   pg_d   = pg_q;
    pid_d   = pid_q;    slot_d = slot_q;  need_d = need_q; act_d  = act_q;
    sc_d    = sc_q;     off_d  = off_q;   aoff_d = aoff_q; pbase_d = pbase_q;
    rk_d    = rk_q;     wn_d   = wn_q;    rbuf_d = rbuf_q; wbuf_d = wbuf_q;
    cnt_d   = cnt_q;
    m_we = 1'b0; m_addr = pbase_q + AW'(aoff_q) + AW'(rk_q); m_wdata = wbuf_q[7:0];
    s_we = 1'b0; s_addr = cnt_q[11:0]; s_wdata = req_i.data_byte;
    fin = 1'b0; f_st = ST_OK; f_page = '0; f_slot = '0; f_off = '0; f_len = '0;
    f_data = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pid_d   = req_i.page_id;
          slot_d  = req_i.slot_id;
          need_d  = req_i.record_length;
          act_d   = req_i.action;
          pbase_d = AW'(32'(req_i.page_id) * PAGE_BYTES);
          case (action_e'(req_i.action))
            ACT_STAGE: begin
              s_we   = 1'b1;
              s_addr = req_i.byte_index;
              fin    = 1'b1;
            end
            ACT_INSERT: state_d = S_INS_START;
            ACT_LOOKUP, ACT_UPDATE, ACT_DELETE: state_d = S_SO_START;
            ACT_READ: begin
              if (32'(req_i.page_id) >= PAGE_COUNT ||
                  32'(req_i.byte_index) >= PAGE_BYTES) begin
                fin    = 1'b1;
                f_st   = ST_NOT_FOUND;
                f_page = req_i.page_id;
              end else begin
                m_addr  = AW'(32'(req_i.page_id) * PAGE_BYTES + 32'(req_i.byte_index));
                state_d = S_RB;
              end
            end
            default: begin
              fin  = 1'b1;
              f_st = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_RB: begin
        fin     = 1'b1;
        f_page  = pid_q;
        f_data  = m_rdata;
        state_d = S_IDLE;
      end
      S_RD: begin
        // Byte k is addressed in step k and lands in the next step.
        if (rk_q != 3'd0) begin
          rbuf_d = {m_rdata, rbuf_q[31:8]};
        end
        if (rk_q == 3'd4) begin
          rk_d    = 3'd0;
          state_d = ret_q;
        end else begin
          rk_d = rk_q + 3'd1;
        end
      end
      S_WR: begin
        m_we   = 1'b1;
        wbuf_d = {8'd0, wbuf_q[31:8]};
        if (rk_q == wn_q - 3'd1) begin
          rk_d    = 3'd0;
          state_d = ret_q;
        end else begin
          rk_d = rk_q + 3'd1;
        end
      end
      S_COPY: begin
        // Staging read and page write overlap, one byte behind.
        if (cnt_q != 13'd0) begin
          m_we    = 1'b1;
          m_addr  = pbase_q + AW'(off_q) + AW'(cnt_q - 13'd1);
          m_wdata = s_rdata;
        end
        if (cnt_q == {1'b0, need_q}) begin
          state_d = ret_q;
        end else begin
          cnt_d = cnt_q + 13'd1;
        end
      end
      S_INS_START: begin
        if (32'(need_q) + 32'd8 > PAGE_BYTES) begin
          fin     = 1'b1;
          f_st    = ST_TOO_LARGE;
          state_d = S_IDLE;
        end else begin
          pg_d    = '0;
          state_d = S_INS_PG;
        end
      end
      S_INS_PG: begin
        if (32'(pg_q) >= 32'(piu_q) || 32'(pg_q) >= PAGE_COUNT) begin
          state_d = S_INS_NEW;
        end else begin
          pbase_d = AW'(32'(pg_q) * PAGE_BYTES);
          aoff_d  = '0;
          rk_d    = '0;
          ret_d   = S_INS_CHK;
          state_d = S_RD;
        end
      end
      S_INS_CHK: begin
        if (room >= 18'(need_q) + 18'd4) begin
          sc_d    = hdr_sc;
          off_d   = hdr_fp - 16'(need_q);
          cnt_d   = '0;
          ret_d   = S_PLACE_W;
          state_d = S_COPY;
        end else begin
          pg_d    = pg_q + PCW'(1);
          state_d = S_INS_PG;
        end
      end
      S_INS_NEW: begin
        if (32'(piu_q) >= PAGE_COUNT) begin
          fin     = 1'b1;
          f_st    = ST_FULL;
          state_d = S_IDLE;
        end else begin
          pg_d    = piu_q;
          piu_d   = piu_q + PCW'(1);
          pbase_d = AW'(32'(piu_q) * PAGE_BYTES);
          sc_d    = '0;
          off_d   = 16'(PAGE_BYTES) - 16'(need_q);
          cnt_d   = '0;
          ret_d   = S_PLACE_W;
          state_d = S_COPY;
        end
      end
      S_PLACE_W: begin
        wbuf_d  = {16'(need_q), off_q};
        aoff_d  = 16'd4 + {sc_q[13:0], 2'b00};
        wn_d    = 3'd4;
        rk_d    = '0;
        ret_d   = S_PLACE_H;
        state_d = S_WR;
      end
      S_PLACE_H: begin
        wbuf_d  = {off_q, sc_q + 16'd1};
        aoff_d  = '0;
        wn_d    = 3'd4;
        rk_d    = '0;
        ret_d   = S_FIN_INS;
        state_d = S_WR;
      end
      S_FIN_INS: begin
        fin     = 1'b1;
        f_page  = 4'(pg_q);
        f_slot  = sc_q[9:0];
        f_off   = off_q[11:0];
        f_len   = need_q;
        state_d = S_IDLE;
      end
      S_SO_START: begin
        if (32'(pid_q) >= 32'(piu_q) || 32'(pid_q) >= PAGE_COUNT) begin
          fin     = 1'b1;
          f_st    = ST_NOT_FOUND;
          f_page  = pid_q;
          f_slot  = slot_q;
          state_d = S_IDLE;
        end else begin
          aoff_d  = '0;
          rk_d    = '0;
          ret_d   = S_SO_HCHK;
          state_d = S_RD;
        end
      end
      S_SO_HCHK: begin
        if (16'(slot_q) >= hdr_sc) begin
          fin     = 1'b1;
          f_st    = ST_NOT_FOUND;
          f_page  = pid_q;
          f_slot  = slot_q;
          state_d = S_IDLE;
        end else begin
          aoff_d  = slot_ent;
          rk_d    = '0;
          ret_d   = S_SO_ACT;
          state_d = S_RD;
        end
      end
      S_SO_ACT: begin
        off_d  = rbuf_q[15:0];
        wbuf_d = '0;
        aoff_d = slot_ent + 16'd2;
        wn_d   = 3'd2;
        rk_d   = '0;
        f_page = pid_q;
        f_slot = slot_q;
        f_off  = rbuf_q[11:0];
        case (action_e'(act_q))
          ACT_LOOKUP: begin
            fin     = 1'b1;
            f_len   = rbuf_q[27:16];
            f_st    = (rbuf_q[31:16] == 16'd0) ? ST_DELETED : ST_OK;
            state_d = S_IDLE;
          end
          ACT_DELETE: begin
            ret_d   = S_FIN_DEL;
            state_d = S_WR;
          end
          default: begin
            if (rbuf_q[31:16] == 16'd0) begin
              fin     = 1'b1;
              f_st    = ST_DELETED;
              state_d = S_IDLE;
            end else if (16'(need_q) <= rbuf_q[31:16]) begin
              cnt_d   = '0;
              ret_d   = S_UPD_W;
              state_d = S_COPY;
            end else begin
              // Tombstone the old slot, then place the record afresh.
              ret_d   = S_INS_START;
              state_d = S_WR;
            end
          end
        endcase
      end
      S_UPD_W: begin
        wbuf_d  = {16'd0, 16'(need_q)};
        aoff_d  = slot_ent + 16'd2;
        wn_d    = 3'd2;
        rk_d    = '0;
        ret_d   = S_FIN_UPD;
        state_d = S_WR;
      end
      S_FIN_UPD: begin
        fin     = 1'b1;
        f_page  = pid_q;
        f_slot  = slot_q;
        f_off   = off_q[11:0];
        f_len   = need_q;
        state_d = S_IDLE;
      end
      S_FIN_DEL: begin
        fin     = 1'b1;
        f_page  = pid_q;
        f_slot  = slot_q;
        f_off   = off_q[11:0];
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      piu_q   <= '0;
      rk_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      piu_q   <= piu_d;
      rk_q    <= rk_d;
      if (fin) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q    <= pg_d;
    pid_q   <= pid_d;
    slot_q  <= slot_d;
    need_q  <= need_d;
    act_q   <= act_d;
    sc_q    <= sc_d;
    off_q   <= off_d;
    aoff_q  <= aoff_d;
    pbase_q <= pbase_d;
    wn_q    <= wn_d;
    rbuf_q  <= rbuf_d;
    wbuf_q  <= wbuf_d;
    cnt_q   <= cnt_d;
    if (fin) begin
      st_q    <= f_st;
      rpage_q <= f_page;
      rslot_q <= f_slot;
      roff_q  <= f_off;
      rlen_q  <= f_len;
      rdat_q  <= f_data;
    end
  end

  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = st_q;
  assign rsp_o.result_page   = rpage_q;
  assign rsp_o.result_slot   = rslot_q;
  assign rsp_o.record_offset = roff_q;
  assign rsp_o.stored_length = rlen_q;
  assign rsp_o.read_data     = rdat_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == S_IDLE))
    else $error("request taken while the sequencer is busy");

  a_piu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(piu_q) <= PAGE_COUNT)
    else $error("page count beyond the store size");

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> (cnt_q <= {1'b0, need_q}))
    else $error("record copy ran past its length");

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && state_q != S_IDLE) |-> !ov_q)
    else $error("response produced while the previous one is still held");

endmodule
`default_nettype wire

// ===== bench/slotted_page_record_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted page record store core testbench
// Drives request beats from a queue and checks every response beat against a
// shadow of the page store that is updated as each request is queued. Covers
// staging, insert, lookup, update, delete, read byte and unknown actions,
// with random idling on both channels and a fill up to a full store.
// ----------------------------------------------------------------------------
module slotted_page_record_store_core_tb;
  import spr_pkg::*;

  localparam int PG_BYTES = 4096;
  localparam int PG_COUNT = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int STAGE_FILL = 512;

  // Action codes that the core does not define.
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   page_id;
    logic [SLOT_W-1:0]   slot_id;
    logic [INDEX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    record_length;
  } store_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [SLOT_W-1:0]   slot;
    logic [INDEX_W-1:0]  offset;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   data;
  } store_rsp_t;

  logic clk_i;
  logic rst_ni;

  spr_req_if req_bus ();
  spr_rsp_if rsp_bus ();

  slotted_page_record_store_core #(
    .PAGE_BYTES(PG_BYTES),
    .PAGE_COUNT(PG_COUNT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus.sink),
    .rsp_o (rsp_bus.source)
  );

  // Shadow of the store.
  logic [7:0]  shadow_page [0:PG_BYTES*PG_COUNT-1];
  bit          page_written [0:PG_BYTES*PG_COUNT-1];
  logic [7:0]  shadow_stage [0:STAGE_BYTES-1];
  bit          stage_written [0:STAGE_BYTES-1];
  int          stage_prefix;
  int          pages_used;

  store_req_t  pending_reqs [$];
  store_rsp_t  awaited_rsps [$];
  int          mismatches;
  int          status_seen [0:7];
  int          req_gap;
  int          rsp_stall;
  int          hold_left;
  bit          hold_go;
  bit          hold_done;
  bit          tx_burst;
  bit          rx_burst;
  int          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int rd8(int pg, int off);
    return int'(shadow_page[pg*PG_BYTES + off]);
  endfunction

  function automatic int rd16(int pg, int off);
    return rd8(pg, off) | (rd8(pg, off + 1) << 8);
  endfunction

  function automatic void wr8(int pg, int off, int v);
    if (off >= PG_BYTES) return;
    shadow_page[pg*PG_BYTES + off] = v[7:0];
    page_written[pg*PG_BYTES + off] = 1'b1;
  endfunction

  function automatic void wr16(int pg, int off, int v);
    wr8(pg, off, v & 8'hFF);
    wr8(pg, off + 1, (v >> 8) & 8'hFF);
  endfunction

  function automatic void copy_stage(int pg, int off, int len);
    for (int i = 0; i < len; i++) wr8(pg, off + i, int'(shadow_stage[i]));
  endfunction

  function automatic store_rsp_t place_record(int pg, int sc, int fp, int need);
    store_rsp_t r;
    int off;
    r = '{default: '0};
    off = fp - need;
    copy_stage(pg, off, need);
    wr16(pg, 4 + sc*4, off);
    wr16(pg, 6 + sc*4, need);
    wr16(pg, 0, sc + 1);
    wr16(pg, 2, off);
    r.status = ST_OK;
    r.page = PAGE_W'(pg);
    r.slot = SLOT_W'(sc);
    r.offset = INDEX_W'(off);
    r.length = LEN_W'(need);
    return r;
  endfunction

  function automatic store_rsp_t insert_record(int need);
    store_rsp_t r;
    int sc, fp, dir_end, room, pg;
    r = '{default: '0};
    if (need + 8 > PG_BYTES) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    for (int p = 0; p < pages_used; p++) begin
      sc = rd16(p, 0);
      fp = rd16(p, 2);
      dir_end = 4 + sc*4;
      room = fp > dir_end ? fp - dir_end : 0;
      if (room >= need + 4) return place_record(p, sc, fp, need);
    end
    if (pages_used >= PG_COUNT) begin
      r.status = ST_FULL;
      return r;
    end
    pg = pages_used;
    pages_used++;
    wr16(pg, 0, 0);
    wr16(pg, 2, PG_BYTES);
    return place_record(pg, 0, PG_BYTES, need);
  endfunction

  function automatic store_rsp_t predict_store(store_req_t q);
    store_rsp_t r;
    int pg, sl, soff, slen, rlen;
    r = '{default: '0};
    pg = int'(q.page_id);
    sl = int'(q.slot_id);
    rlen = int'(q.record_length);
    case (q.action)
      ACT_STAGE: begin
        shadow_stage[q.byte_index] = q.data_byte;
        stage_written[q.byte_index] = 1'b1;
        while (stage_prefix < STAGE_BYTES && stage_written[stage_prefix]) stage_prefix++;
        r.status = ST_OK;
      end
      ACT_INSERT: r = insert_record(rlen);
      ACT_LOOKUP, ACT_UPDATE, ACT_DELETE: begin
        r.page = q.page_id;
        r.slot = q.slot_id;
        if (pg >= pages_used || sl >= rd16(pg, 0)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          soff = rd16(pg, 4 + sl*4);
          slen = rd16(pg, 6 + sl*4);
          r.offset = INDEX_W'(soff);
          if (q.action == ACT_LOOKUP) begin
            r.length = LEN_W'(slen);
            r.status = slen == 0 ? ST_DELETED : ST_OK;
          end else if (q.action == ACT_DELETE) begin
            wr16(pg, 6 + sl*4, 0);
            r.status = ST_OK;
          end else if (slen == 0) begin
            r.status = ST_DELETED;
          end else if (rlen <= slen) begin
            copy_stage(pg, soff, rlen);
            wr16(pg, 6 + sl*4, rlen);
            r.length = LEN_W'(rlen);
            r.status = ST_OK;
          end else begin
            wr16(pg, 6 + sl*4, 0);
            r = insert_record(rlen);
          end
        end
      end
      ACT_READ: begin
        r.page = q.page_id;
        r.data = BYTE_W'(rd8(pg, int'(q.byte_index)));
        r.status = ST_OK;
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    return r;
  endfunction

  task automatic send_req(logic [ACTION_W-1:0] act, int pg, int sl, int idx, int dat,
                          int len);
    store_req_t q;
    q.action = act;
    q.page_id = PAGE_W'(pg);
    q.slot_id = SLOT_W'(sl);
    q.byte_index = INDEX_W'(idx);
    q.data_byte = BYTE_W'(dat);
    q.record_length = LEN_W'(len);
    awaited_rsps = {awaited_rsps, predict_store(q)};
    pending_reqs = {pending_reqs, q};
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || awaited_rsps.size() != 0) @(negedge clk_i);
  endtask

  // Length that the staged prefix can cover, so no unwritten byte is copied.
  function automatic int pick_len(int cap);
    int hi;
    hi = cap < stage_prefix ? cap : stage_prefix;
    return $urandom_range(0, hi);
  endfunction

  task automatic send_random();
    int sel, pg, sl, idx, len, cnt, fp;
    sel = $urandom_range(0, 99);
    pg = (pages_used > 0 && $urandom_range(0, 9) < 8) ?
         $urandom_range(0, pages_used - 1) : $urandom_range(0, 15);
    cnt = pg < pages_used ? rd16(pg, 0) : 0;
    sl = $urandom_range(0, 9) < 8 ? $urandom_range(0, cnt) : $urandom_range(0, 1023);
    if (sel < 25) begin
      idx = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) :
            $urandom_range(0, stage_prefix < 4095 ? stage_prefix : 4095);
      send_req(ACT_STAGE, $urandom, $urandom, idx, $urandom, $urandom);
    end else if (sel < 45) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(4089, 4095);
        1:       len = pick_len(1000);
        default: len = pick_len(48);
      endcase
      send_req(ACT_INSERT, $urandom, $urandom, $urandom, $urandom, len);
    end else if (sel < 63) begin
      send_req(ACT_LOOKUP, pg, sl, $urandom, $urandom, $urandom);
    end else if (sel < 75) begin
      len = pick_len(64);
      if ($urandom_range(0, 29) == 0) len = $urandom_range(4089, 4095);
      send_req(ACT_UPDATE, pg, sl, $urandom, $urandom, len);
    end else if (sel < 83) begin
      send_req(ACT_DELETE, pg, sl, $urandom, $urandom, $urandom);
    end else if (sel < 97) begin
      idx = $urandom_range(0, 4095);
      if (!page_written[pg*PG_BYTES + idx]) begin
        if (pages_used == 0) begin
          send_req(ACT_LOOKUP, pg, sl, $urandom, $urandom, $urandom);
          return;
        end
        pg = $urandom_range(0, pages_used - 1);
        fp = rd16(pg, 2);
        idx = (fp < PG_BYTES && $urandom_range(0, 1)) ?
              $urandom_range(fp, PG_BYTES - 1) : $urandom_range(0, 3);
      end
      send_req(ACT_READ, pg, $urandom, idx, $urandom, $urandom);
    end else begin
      send_req(ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_B)), $urandom, $urandom,
               $urandom, $urandom, $urandom);
    end
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && !req_bus.ready) begin
        // Beat held until taken.
      end else if (req_gap > 0) begin
        req_bus.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        store_req_t q;
        q = pending_reqs.pop_front();
        req_bus.action        <= q.action;
        req_bus.page_id       <= q.page_id;
        req_bus.slot_id       <= q.slot_id;
        req_bus.byte_index    <= q.byte_index;
        req_bus.data_byte     <= q.data_byte;
        req_bus.record_length <= q.record_length;
        req_bus.valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) tx_burst <= ~tx_burst;
        req_gap <= tx_burst ? 0 : $urandom_range(0, 16);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response monitor and ready generation.
  always @(posedge clk_i) begin
    int d;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        store_rsp_t e;
        if (awaited_rsps.size() == 0) begin
          $display("%0t: response beat with nothing awaited, status %0d", $time,
                   rsp_bus.status);
          mismatches++;
        end else begin
          e = awaited_rsps.pop_front();
          status_seen[rsp_bus.status]++;
          if (rsp_bus.status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, rsp_bus.status);
            mismatches++;
          end
          if (rsp_bus.result_page !== e.page) begin
            $display("%0t: page expected %0d got %0d", $time, e.page, rsp_bus.result_page);
            mismatches++;
          end
          if (rsp_bus.result_slot !== e.slot) begin
            $display("%0t: slot expected %0d got %0d", $time, e.slot, rsp_bus.result_slot);
            mismatches++;
          end
          if (rsp_bus.record_offset !== e.offset) begin
            $display("%0t: offset expected %0d got %0d", $time, e.offset,
                     rsp_bus.record_offset);
            mismatches++;
          end
          if (rsp_bus.stored_length !== e.length) begin
            $display("%0t: length expected %0d got %0d", $time, e.length,
                     rsp_bus.stored_length);
            mismatches++;
          end
          if (rsp_bus.read_data !== e.data) begin
            $display("%0t: read data expected %0h got %0h", $time, e.data,
                     rsp_bus.read_data);
            mismatches++;
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_bus.ready <= (hold_left == 1);
      end else if (rsp_bus.valid && rsp_bus.ready) begin
        if ($urandom_range(0, 63) == 0) rx_burst <= ~rx_burst;
        d = rx_burst ? 0 : $urandom_range(0, 16);
        rsp_stall <= d;
        rsp_bus.ready <= (d == 0);
      end else if (rsp_stall > 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp_bus.ready <= (rsp_stall == 1);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.action = '0;
    req_bus.page_id = '0;
    req_bus.slot_id = '0;
    req_bus.byte_index = '0;
    req_bus.data_byte = '0;
    req_bus.record_length = '0;
    rsp_bus.ready = 1'b0;
    req_gap = 0;
    rsp_stall = 0;
    hold_left = 0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    idle_cycles = 0;
    mismatches = 0;
    stage_prefix = 0;
    pages_used = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: boundaries and the special cases.
    send_req(ACT_LOOKUP, 0, 0, 0, 0, 0);             // nothing allocated yet
    send_req(ACT_INSERT, 15, 1023, 4095, 255, 0);     // zero-length record
    send_req(ACT_LOOKUP, 0, 0, 0, 0, 0);             // reads as a tombstone
    send_req(ACT_STAGE, 0, 0, 4095, 8'hFF, 0);
    send_req(ACT_STAGE, 0, 0, 0, 8'hA5, 0);
    send_req(ACT_STAGE, 0, 0, 1, 8'h00, 0);
    send_req(ACT_INSERT, 0, 0, 0, 0, 4095);           // too large
    send_req(ACT_INSERT, 0, 0, 0, 0, 2);
    send_req(ACT_READ, 0, 0, 4094, 0, 0);
    send_req(ACT_READ, 0, 0, 0, 0, 0);
    send_req(ACT_UPDATE, 0, 1, 0, 0, 1);              // fits in place
    send_req(ACT_UPDATE, 0, 1, 0, 0, 2);              // grows, moves
    send_req(ACT_LOOKUP, 0, 1, 0, 0, 0);
    send_req(ACT_UPDATE, 0, 1, 0, 0, 1);              // tombstone
    send_req(ACT_DELETE, 0, 2, 0, 0, 0);
    send_req(ACT_DELETE, 0, 2, 0, 0, 0);              // already deleted
    send_req(ACT_UPDATE, 0, 1023, 0, 0, 1);           // out of range
    send_req(ACT_LOOKUP, 15, 0, 0, 0, 0);
    send_req(ACT_SPARE_A, 0, 0, 0, 0, 0);
    send_req(ACT_SPARE_B, 15, 1023, 4095, 255, 4095);
    wait_drained();

    // Stage a block of bytes that records can be copied from.
    for (int i = 0; i < STAGE_FILL; i++) send_req(ACT_STAGE, 0, 0, i, $urandom, 0);
    wait_drained();

    for (int i = 0; i < 180; i++) begin
      send_random();
      if (i == 60) begin
        while (pending_reqs.size() != 0) @(negedge clk_i);
        hold_go = 1'b1;
        for (int k = 0; k < 20; k++) send_random();
      end
      if (i == 120) wait_drained();
      if (pending_reqs.size() > 8) @(negedge clk_i);
    end

    // Large records until every page is taken.
    for (int i = 0; i < 150; i++) begin
      send_req(ACT_INSERT, 0, 0, 0, 0, $urandom_range(450, 500));
      while (pending_reqs.size() > 4) @(negedge clk_i);
    end
    for (int i = 0; i < 40; i++) begin
      send_random();
      while (pending_reqs.size() > 8) @(negedge clk_i);
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Run covered %0d ok, %0d too large, %0d not found, %0d deleted, %0d full",
             status_seen[ST_OK], status_seen[ST_TOO_LARGE], status_seen[ST_NOT_FOUND],
             status_seen[ST_DELETED], status_seen[ST_FULL]);
    $display("Pages in use at the end: %0d of %0d", pages_used, PG_COUNT);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spr_pkg.sv
rtl/spr_if.sv
rtl/spr_ram.sv
rtl/slotted_page_record_store_core.sv
bench/slotted_page_record_store_core_tb.sv
